// ===== rtl/abd_pkg.sv =====
package abd_pkg;

  // Register and field widths
  localparam int DIM_W   = 13;
  localparam int TGT_W   = 9;
  localparam int ALPHA_W = 8;
  localparam int POS_W   = 8;
  localparam int SUM_W   = 2 * DIM_W + ALPHA_W;
  localparam int PROD_W  = 2 * DIM_W;
  localparam int IDX_W   = 2;

  localparam int MAX_SOURCE_DEF = 4096;
  localparam int MAX_TARGET_DEF = 256;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(256);
  localparam logic [TGT_W-1:0] TARGET_RST = TGT_W'(32);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_TARGET_SIZE = 2'd2;

  // Multiplier operand selects
  localparam logic [2:0] MUL_COUNT = 3'd0;
  localparam logic [2:0] MUL_COL   = 3'd1;
  localparam logic [2:0] MUL_ROW   = 3'd2;
  localparam logic [2:0] MUL_SETW  = 3'd3;
  localparam logic [2:0] MUL_SETH  = 3'd4;

  typedef struct packed {
    logic       cfg_write;
    logic       accept;
    logic       sum_load;
    logic       mul_go;
    logic [2:0] mul_sel;
    logic       div_start;
    logic       div_mean;
    logic       write_sum;
    logic       clear_entry;
    logic       out_load;
    logic       col_step;
    logic       col_adv;
    logic       col_load_end;
    logic       line_wrap;
    logic       row_step;
    logic       row_load_end;
    logic       frame_start;
    logic       first_w_load;
    logic       first_h_load;
  } abd_cmd_t;

  typedef struct packed {
    logic cfg_ok;
    logic cfg_hit;
    logic col_last;
    logic row_last;
    logic line_end;
    logic frame_end;
    logic div_done;
    logic out_free;
  } abd_stat_t;

endpackage

// ===== rtl/alpha_box_downscaler.sv =====
// Alpha box downscaler: area-average reduction of an alpha plane to a
// square target_size x target_size image.
//
// Channels (valid/ready, a request moves when both are high):
//   cfg  : cfg_index/cfg_data write src_width (0), src_height (1) or
//          target_size (2). Any of these restarts the frame. Taken only idle,
//          ahead of a waiting in request.
//   in   : one src_alpha byte per request, source raster order.
//   out  : one cell mean with its out_x/out_y, frame_last on the final cell.
// Steps: a request with no result runs accept, sum read, accumulate and
//   position update. A request that closes a cell adds the shift/subtract
//   divide of sum by cell area before its result is loaded. Crossing into
//   the next column or row band adds the band edge divide
//   ((index + 1) * size / target_size). The single divider is shared by
//   the mean and band edge divides.
// Reset and each restarting register write run a setup that computes the
//   first band edges; in and cfg are not ready meanwhile.
// Unusable register settings consume requests without results.
// Output stall: the result sits in an output register; the next request is
//   still taken and only stops before loading a result while one is pending.
module alpha_box_downscaler import abd_pkg::*; #(
  parameter int MAX_SOURCE = MAX_SOURCE_DEF,
  parameter int MAX_TARGET = MAX_TARGET_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ALPHA_W-1:0] src_alpha,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ALPHA_W-1:0] out_alpha,
  output logic [POS_W-1:0]   out_x,
  output logic [POS_W-1:0]   out_y,
  output logic               frame_last
);

  abd_cmd_t  cmd;
  abd_stat_t stat;

  // sequencing of accumulate, divide and band updates
  abd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // column sums, counters, multiplier, divider, result register
  abd_dp #(
    .MAX_SOURCE (MAX_SOURCE),
    .MAX_TARGET (MAX_TARGET)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .src_alpha  (src_alpha),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_alpha  (out_alpha),
    .out_x      (out_x),
    .out_y      (out_y),
    .frame_last (frame_last)
  );

endmodule

// ===== rtl/abd_ram.sv =====
module abd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/abd_div.sv =====
module abd_div #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic         busy,
  output logic         done
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     den;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  assign shifted = {rem, quotient[W-1]};
  assign diff    = shifted - {1'b0, den};

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      den      <= divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        rem      <= diff[W-1:0];
        quotient <= {quotient[W-2:0], 1'b1};
      end else begin
        rem      <= shifted[W-1:0];
        quotient <= {quotient[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/abd_ctrl.sv =====
module abd_ctrl import abd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  abd_stat_t stat,
  output abd_cmd_t  cmd
);

  localparam logic [4:0] ST_SW_MUL = 5'd0;
  localparam logic [4:0] ST_SW_DVS = 5'd1;
  localparam logic [4:0] ST_SW_DIV = 5'd2;
  localparam logic [4:0] ST_SH_MUL = 5'd3;
  localparam logic [4:0] ST_SH_DVS = 5'd4;
  localparam logic [4:0] ST_SH_DIV = 5'd5;
  localparam logic [4:0] ST_FS     = 5'd6;
  localparam logic [4:0] ST_IDLE   = 5'd7;
  localparam logic [4:0] ST_RD     = 5'd8;
  localparam logic [4:0] ST_ACC    = 5'd9;
  localparam logic [4:0] ST_MDIV   = 5'd10;
  localparam logic [4:0] ST_OUT    = 5'd11;
  localparam logic [4:0] ST_ADV    = 5'd12;
  localparam logic [4:0] ST_C_MUL  = 5'd13;
  localparam logic [4:0] ST_C_DVS  = 5'd14;
  localparam logic [4:0] ST_C_DIV  = 5'd15;
  localparam logic [4:0] ST_R_MUL  = 5'd16;
  localparam logic [4:0] ST_R_DVS  = 5'd17;
  localparam logic [4:0] ST_R_DIV  = 5'd18;

  logic [4:0] state;
  logic [4:0] state_next;

  // a waiting cfg request goes first, so in is held off meanwhile
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SW_MUL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_COUNT;
    state_next = state;
    unique case (state)
      ST_SW_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_SETW;
        state_next  = ST_SW_DVS;
      end
      ST_SW_DVS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_SW_DIV;
      end
      ST_SW_DIV: begin
        if (stat.div_done) begin
          cmd.first_w_load = 1'b1;
          state_next       = ST_SH_MUL;
        end
      end
      ST_SH_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_SETH;
        state_next  = ST_SH_DVS;
      end
      ST_SH_DVS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_SH_DIV;
      end
      ST_SH_DIV: begin
        if (stat.div_done) begin
          cmd.first_h_load = 1'b1;
          state_next       = ST_FS;
        end
      end
      ST_FS: begin
        cmd.frame_start = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          if (stat.cfg_hit) begin
            state_next = ST_SW_MUL;
          end
        end else if (in_valid && stat.cfg_ok) begin
          cmd.accept = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.sum_load = 1'b1;
        cmd.mul_go   = 1'b1;
        cmd.mul_sel  = MUL_COUNT;
        state_next   = ST_ACC;
      end
      ST_ACC: begin
        if (stat.col_last && stat.row_last) begin
          cmd.div_start = 1'b1;
          cmd.div_mean  = 1'b1;
          state_next    = ST_MDIV;
        end else begin
          cmd.write_sum = 1'b1;
          state_next    = ST_ADV;
        end
      end
      ST_MDIV: begin
        if (stat.div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.clear_entry = 1'b1;
          state_next      = ST_ADV;
        end
      end
      ST_ADV: begin
        if (!stat.line_end) begin
          cmd.col_step = 1'b1;
          if (stat.col_last) begin
            cmd.col_adv = 1'b1;
            state_next  = ST_C_MUL;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          cmd.line_wrap = 1'b1;
          if (stat.frame_end) begin
            cmd.frame_start = 1'b1;
            state_next      = ST_IDLE;
          end else if (stat.row_last) begin
            cmd.row_step = 1'b1;
            state_next   = ST_R_MUL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_C_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_COL;
        state_next  = ST_C_DVS;
      end
      ST_C_DVS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_C_DIV;
      end
      ST_C_DIV: begin
        if (stat.div_done) begin
          cmd.col_load_end = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_R_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_ROW;
        state_next  = ST_R_DVS;
      end
      ST_R_DVS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_R_DIV;
      end
      ST_R_DIV: begin
        if (stat.div_done) begin
          cmd.row_load_end = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SW_MUL;
      end
    endcase
  end

endmodule

// ===== rtl/abd_dp.sv =====
module abd_dp import abd_pkg::*; #(
  parameter int MAX_SOURCE = MAX_SOURCE_DEF,
  parameter int MAX_TARGET = MAX_TARGET_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  abd_cmd_t           cmd,
  output abd_stat_t          stat,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]   cfg_data,
  input  logic [ALPHA_W-1:0] src_alpha,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ALPHA_W-1:0] out_alpha,
  output logic [POS_W-1:0]   out_x,
  output logic [POS_W-1:0]   out_y,
  output logic               frame_last
);

  localparam int TCW = $clog2(MAX_TARGET);

  logic [DIM_W-1:0]   src_width;
  logic [DIM_W-1:0]   src_height;
  logic [TGT_W-1:0]   target_size;

  logic [DIM_W-1:0]   source_col;
  logic [DIM_W-1:0]   source_row;
  logic [TCW-1:0]     target_col;
  logic [TCW-1:0]     target_row;
  logic [DIM_W-1:0]   col_band_start;
  logic [DIM_W-1:0]   col_band_end;
  logic [DIM_W-1:0]   row_band_start;
  logic [DIM_W-1:0]   row_band_end;
  logic [DIM_W-1:0]   first_col_end;
  logic [DIM_W-1:0]   first_row_end;

  logic [MAX_TARGET-1:0] sum_valid;
  logic [ALPHA_W-1:0]    alpha;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      ram_rdata;
  logic [DIM_W-1:0]      mul_a;
  logic [DIM_W-1:0]      mul_b;
  logic [PROD_W-1:0]     product;

  logic [SUM_W-1:0] div_dividend;
  logic [SUM_W-1:0] div_divisor;
  logic [SUM_W-1:0] quotient;
  logic             div_busy;
  logic             div_done;

  // configuration registers and validity
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= WIDTH_RST;
      src_height  <= HEIGHT_RST;
      target_size <= TARGET_RST;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:   src_width   <= cfg_data;
        REG_SRC_HEIGHT:  src_height  <= cfg_data;
        REG_TARGET_SIZE: target_size <= cfg_data[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.cfg_ok = (src_width != '0) && (src_height != '0) && (target_size != '0) &&
                  (32'(src_width) <= 32'(MAX_SOURCE)) &&
                  (32'(src_height) <= 32'(MAX_SOURCE)) &&
                  (32'(target_size) <= 32'(MAX_TARGET)) &&
                  (DIM_W'(target_size) <= src_width) &&
                  (DIM_W'(target_size) <= src_height);
    stat.cfg_hit   = (cfg_index == REG_SRC_WIDTH) || (cfg_index == REG_SRC_HEIGHT) ||
                     (cfg_index == REG_TARGET_SIZE);
    stat.col_last  = (source_col + DIM_W'(1)) == col_band_end;
    stat.row_last  = (source_row + DIM_W'(1)) == row_band_end;
    stat.line_end  = (source_col + DIM_W'(1)) >= src_width;
    stat.frame_end = (source_row + DIM_W'(1)) >= src_height;
    stat.div_done  = div_done;
    stat.out_free  = !out_valid || out_ready;
  end

  // position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      source_col     <= '0;
      source_row     <= '0;
      target_col     <= '0;
      target_row     <= '0;
      col_band_start <= '0;
      row_band_start <= '0;
      sum_valid      <= '0;
    end else if (cmd.frame_start) begin
      source_col     <= '0;
      source_row     <= '0;
      target_col     <= '0;
      target_row     <= '0;
      col_band_start <= '0;
      row_band_start <= '0;
      col_band_end   <= first_col_end;
      row_band_end   <= first_row_end;
      sum_valid      <= '0;
    end else begin
      if (cmd.write_sum) begin
        sum_valid[target_col] <= 1'b1;
      end
      if (cmd.clear_entry) begin
        sum_valid[target_col] <= 1'b0;
      end
      if (cmd.col_step) begin
        source_col <= source_col + DIM_W'(1);
      end
      if (cmd.col_adv) begin
        col_band_start <= col_band_end;
        target_col     <= target_col + TCW'(1);
      end
      if (cmd.col_load_end) begin
        col_band_end <= quotient[DIM_W-1:0];
      end
      if (cmd.line_wrap) begin
        source_col     <= '0;
        target_col     <= '0;
        col_band_start <= '0;
        col_band_end   <= first_col_end;
        source_row     <= source_row + DIM_W'(1);
      end
      if (cmd.row_step) begin
        row_band_start <= row_band_end;
        target_row     <= target_row + TCW'(1);
      end
      if (cmd.row_load_end) begin
        row_band_end <= quotient[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.first_w_load) begin
      first_col_end <= quotient[DIM_W-1:0];
    end
    if (cmd.first_h_load) begin
      first_row_end <= quotient[DIM_W-1:0];
    end
    if (cmd.accept) begin
      alpha <= src_alpha;
    end
    if (cmd.sum_load) begin
      sum <= (sum_valid[target_col] ? ram_rdata : '0) + SUM_W'(alpha);
    end
  end

  abd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_TARGET)
  ) u_sums (
    .clk   (clk),
    .we    (cmd.write_sum),
    .waddr (target_col),
    .wdata (sum),
    .raddr (target_col),
    .rdata (ram_rdata)
  );

  // shared multiplier: cell area or band edge numerator
  always_comb begin
    case (cmd.mul_sel)
      MUL_COUNT: begin
        mul_a = col_band_end - col_band_start;
        mul_b = row_band_end - row_band_start;
      end
      MUL_COL: begin
        mul_a = DIM_W'(target_col) + DIM_W'(1);
        mul_b = src_width;
      end
      MUL_ROW: begin
        mul_a = DIM_W'(target_row) + DIM_W'(1);
        mul_b = src_height;
      end
      MUL_SETW: begin
        mul_a = DIM_W'(1);
        mul_b = src_width;
      end
      default: begin
        mul_a = DIM_W'(1);
        mul_b = src_height;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      product <= mul_a * mul_b;
    end
  end

  assign div_dividend = cmd.div_mean ? sum : SUM_W'(product);
  assign div_divisor  = cmd.div_mean ? SUM_W'(product) : SUM_W'(target_size);

  abd_div #(
    .W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_alpha  <= quotient[ALPHA_W-1:0];
      out_x      <= POS_W'(target_col);
      out_y      <= POS_W'(target_row);
      frame_last <= ((TGT_W'(target_col) + TGT_W'(1)) == target_size) &&
                    ((TGT_W'(target_row) + TGT_W'(1)) == target_size);
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending request");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_last) |-> (out_x == out_y))
    else $error("frame end flagged off the last cell");

endmodule
